/* src/tcd_pkg.sv */
// Package with the request and result types, calendar constants and helpers.
`default_nettype none
package tcd_pkg;
    localparam int MAX_YEAR = 9999;
    localparam int YEAR_W = 17;
    localparam int FIRST_YEAR = 1970;
    localparam int YEARS_PER_CYCLE = 400;
    localparam logic [63:0] EPOCH_GAP_SECS = 64'd11644473600;
    localparam logic [63:0] TICKS_PER_SEC = 64'd10000000;
    localparam logic [63:0] EPOCH_GAP_TICKS = EPOCH_GAP_SECS * TICKS_PER_SEC;
    localparam logic [63:0] SECS_PER_MIN = 64'd60;
    localparam logic [63:0] SECS_PER_HOUR = 64'd3600;
    localparam logic [63:0] SECS_PER_DAY = 64'd86400;
    localparam logic [63:0] DAYS_PER_CYCLE = 64'd146097;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_BEFORE = 2'd1,
        ST_BEYOND = 2'd2
    } t_status;

    typedef struct packed {
        logic        command;
        logic [63:0] timestamp;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } t_res;

    typedef struct packed {
        logic        command;
        logic [63:0] timestamp;
    } t_job;

    // A span given in seconds, expressed in 100 ns ticks when ticks is set.
    function automatic logic [63:0] in_units(input logic [63:0] secs, input logic ticks);
        begin
            return ticks ? secs * TICKS_PER_SEC : secs;
        end
    endfunction

    function automatic logic [63:0] month_span(input logic [3:0] mo, input logic leap,
                                               input logic ticks);
        begin
            unique case (mo)
                4'd4, 4'd6, 4'd9, 4'd11: return in_units(SECS_PER_DAY * 64'd30, ticks);
                4'd2: return leap ? in_units(SECS_PER_DAY * 64'd29, ticks)
                                  : in_units(SECS_PER_DAY * 64'd28, ticks);
                default: return in_units(SECS_PER_DAY * 64'd31, ticks);
            endcase
        end
    endfunction
endpackage
`default_nettype wire

/* src/tcd_front.sv */
// Front end: request intake and a two-entry queue toward the back end.
`default_nettype none
module tcd_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          push,
    output logic               full,
    input  tcd_pkg::t_req      i_req,
    output logic               o_job_valid,
    input  wire logic          i_job_take,
    output tcd_pkg::t_job      o_job
);
    import tcd_pkg::*;

    t_job       r_mem [2];
    logic       r_wp, n_wp, r_rp, n_rp;
    logic [1:0] r_cnt, n_cnt;
    logic       w_push, w_take;

    assign full = (r_cnt == 2'd2);
    assign w_push = push && !full;
    assign o_job_valid = (r_cnt != 2'd0);
    assign w_take = i_job_take && o_job_valid;
    assign o_job = r_mem[r_rp];

    always_comb begin
        n_wp = r_wp ^ w_push;
        n_rp = r_rp ^ w_take;
        n_cnt = r_cnt + {1'b0, w_push} - {1'b0, w_take};
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= '{command: i_req.command, timestamp: i_req.timestamp};
        end
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp <= n_wp;
            r_rp <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    a_cnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n) r_cnt != 2'd3)
        else $error("queue count overflow");
    a_full_no_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        full && !w_take |=> full) else $error("full queue lost an entry");
    a_empty_no_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0) && !w_push |=> (r_cnt == 2'd0)) else $error("phantom entry");
endmodule
`default_nettype wire

/* src/tcd_back.sv */
// Back end: epoch check, year, month, day and time walks, and the result register.
`default_nettype none
module tcd_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_job_valid,
    output logic               o_job_take,
    input  tcd_pkg::t_job      i_job,
    output logic               empty,
    input  wire logic          pop,
    output tcd_pkg::t_res      o_res
);
    import tcd_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b0_0000_0001,
        S_GAP   = 9'b0_0000_0010,
        S_YEAR  = 9'b0_0000_0100,
        S_MONTH = 9'b0_0000_1000,
        S_DAY   = 9'b0_0001_0000,
        S_HOUR  = 9'b0_0010_0000,
        S_MIN   = 9'b0_0100_0000,
        S_SEC   = 9'b0_1000_0000,
        S_DONE  = 9'b1_0000_0000
    } t_state;

    t_state                 r_st, n_st;
    logic                   r_ticks, n_ticks;
    logic [63:0]            r_rest, n_rest;
    logic [YEAR_W-1:0]      r_year, n_year;
    logic [1:0]             r_y4, n_y4;
    logic [6:0]             r_y100, n_y100;
    logic [8:0]             r_y400, n_y400;
    logic [3:0]             r_mo, n_mo;
    logic [4:0]             r_day, n_day;
    logic [4:0]             r_hr, n_hr;
    logic [5:0]             r_mn, n_mn;
    logic [5:0]             r_sec, n_sec;
    t_status                r_status, n_status;
    logic                   r_full, n_full;
    t_res                   r_res, n_res;
    logic                   w_leap, w_pop;
    logic [63:0]            w_cspan, w_yspan, w_mspan, w_dspan, w_hspan, w_nspan;

    assign empty = !r_full;
    assign o_res = r_res;
    assign w_pop = pop && r_full;
    assign o_job_take = (r_st == S_IDLE) && i_job_valid;
    assign w_leap = ((r_y4 == 2'd0) && (r_y100 != 7'd0)) || (r_y400 == 9'd0);
    assign w_cspan = in_units(SECS_PER_DAY * DAYS_PER_CYCLE, r_ticks);
    assign w_yspan = w_leap ? in_units(SECS_PER_DAY * 64'd366, r_ticks)
                            : in_units(SECS_PER_DAY * 64'd365, r_ticks);
    assign w_mspan = month_span(r_mo, w_leap, r_ticks);
    assign w_dspan = in_units(SECS_PER_DAY, r_ticks);
    assign w_hspan = in_units(SECS_PER_HOUR, r_ticks);
    assign w_nspan = in_units(SECS_PER_MIN, r_ticks);

    always_comb begin
        n_st = r_st; n_ticks = r_ticks; n_rest = r_rest; n_year = r_year;
        n_y4 = r_y4; n_y100 = r_y100; n_y400 = r_y400; n_mo = r_mo; n_day = r_day;
        n_hr = r_hr; n_mn = r_mn; n_sec = r_sec; n_status = r_status; n_res = r_res;
        n_full = r_full && !w_pop;
        unique case (r_st)
            S_IDLE: begin
                if (i_job_valid) begin
                    n_ticks = i_job.command;
                    n_rest = i_job.timestamp;
                    n_year = YEAR_W'(FIRST_YEAR);
                    n_y4 = 2'(FIRST_YEAR % 4);
                    n_y100 = 7'(FIRST_YEAR % 100);
                    n_y400 = 9'(FIRST_YEAR % 400);
                    n_mo = 4'd1;
                    n_day = '0;
                    n_hr = '0;
                    n_mn = '0;
                    n_sec = '0;
                    n_status = ST_OK;
                    n_st = i_job.command ? S_GAP : S_YEAR;
                end
            end
            S_GAP: begin
                if (r_rest < EPOCH_GAP_TICKS) begin
                    n_status = ST_BEFORE;
                    n_st = S_DONE;
                end else begin
                    n_rest = r_rest - EPOCH_GAP_TICKS;
                    n_st = S_YEAR;
                end
            end
            S_YEAR: begin
                if (r_year > YEAR_W'(MAX_YEAR)) begin
                    n_status = ST_BEYOND;
                    n_st = S_DONE;
                end else if ((r_year <= YEAR_W'(MAX_YEAR - (YEARS_PER_CYCLE - 1)))
                             && (r_rest >= w_cspan)) begin
                    // Any 400 consecutive years hold the same number of days.
                    n_rest = r_rest - w_cspan;
                    n_year = r_year + YEAR_W'(YEARS_PER_CYCLE);
                end else if (r_rest < w_yspan) begin
                    n_st = S_MONTH;
                end else begin
                    n_rest = r_rest - w_yspan;
                    n_year = r_year + YEAR_W'(1);
                    n_y4 = r_y4 + 2'd1;
                    n_y100 = (r_y100 == 7'd99) ? 7'd0 : r_y100 + 7'd1;
                    n_y400 = (r_y400 == 9'd399) ? 9'd0 : r_y400 + 9'd1;
                end
            end
            S_MONTH: begin
                if (r_mo < 4'd12 && r_rest >= w_mspan) begin
                    n_rest = r_rest - w_mspan;
                    n_mo = r_mo + 4'd1;
                end else begin
                    n_st = S_DAY;
                end
            end
            S_DAY: begin
                if (r_rest >= w_dspan) begin
                    n_rest = r_rest - w_dspan;
                    n_day = r_day + 5'd1;
                end else begin
                    n_st = S_HOUR;
                end
            end
            S_HOUR: begin
                if (r_rest >= w_hspan) begin
                    n_rest = r_rest - w_hspan;
                    n_hr = r_hr + 5'd1;
                end else begin
                    n_st = S_MIN;
                end
            end
            S_MIN: begin
                if (r_rest >= w_nspan) begin
                    n_rest = r_rest - w_nspan;
                    n_mn = r_mn + 6'd1;
                end else begin
                    n_st = S_SEC;
                end
            end
            S_SEC: begin
                if (r_ticks && r_rest >= TICKS_PER_SEC) begin
                    n_rest = r_rest - TICKS_PER_SEC;
                    n_sec = r_sec + 6'd1;
                end else begin
                    if (!r_ticks) begin
                        n_sec = r_rest[5:0];
                    end
                    n_st = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_full || w_pop) begin
                    n_res = '0;
                    n_res.status = r_status;
                    if (r_status == ST_OK) begin
                        n_res.year = r_year[13:0];
                        n_res.month = r_mo;
                        n_res.day = r_day + 5'd1;
                        n_res.hour = r_hr;
                        n_res.minute = r_mn;
                        n_res.second = r_sec;
                    end
                    n_full = 1'b1;
                    n_st = S_IDLE;
                end
            end
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_ticks <= n_ticks; r_rest <= n_rest; r_year <= n_year;
        r_y4 <= n_y4; r_y100 <= n_y100; r_y400 <= n_y400; r_mo <= n_mo; r_day <= n_day;
        r_hr <= n_hr; r_mn <= n_mn; r_sec <= n_sec; r_status <= n_status; r_res <= n_res;
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_full <= 1'b0;
        end else begin
            r_st <= n_st;
            r_full <= n_full;
        end
    end

    a_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n) $onehot(r_st))
        else $error("state not one-hot");
    a_take_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_job_take |=> (r_st == S_GAP) || (r_st == S_YEAR)) else $error("bad start");
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_full && !w_pop |=> r_full && $stable(r_res)) else $error("result overwritten");
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_full && (r_res.status != ST_OK) |-> (r_res.year == '0) && (r_res.month == '0))
        else $error("error result carries a date");
endmodule
`default_nettype wire

/* src/timestamp_to_calendar_date.sv */
// Top level of the timestamp to calendar date converter.
// Channel | Direction | Handshake    | Payload
// request | in        | push / full  | i_req (command, timestamp)
// result  | out       | pop / empty  | o_res (status, date, time of day)
// A request passes through intake, an epoch check for command 1, a walk over 400-year
// blocks and single years past 1970, then month, day, hour and minute walks, a seconds
// walk for command 1, and the posting of the result.
// Reset is synchronous and empties both the request queue and the result register.
// A waiting result stalls only the back end; the front keeps queuing two requests.
`default_nettype none
module timestamp_to_calendar_date (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          push,
    output logic               full,
    input  tcd_pkg::t_req      i_req,
    output logic               empty,
    input  wire logic          pop,
    output tcd_pkg::t_res      o_res
);
    import tcd_pkg::*;

    logic w_job_valid, w_job_take;
    t_job w_job;

    tcd_front u_front (
        .i_clk, .i_rst_n, .push, .full, .i_req,
        .o_job_valid(w_job_valid), .i_job_take(w_job_take), .o_job(w_job)
    );

    tcd_back u_back (
        .i_clk, .i_rst_n, .i_job_valid(w_job_valid), .o_job_take(w_job_take),
        .i_job(w_job), .empty, .pop, .o_res
    );
endmodule
`default_nettype wire

/* test/tb_timestamp_to_calendar_date.sv */
// Self-checking testbench for the timestamp to calendar date converter.
`default_nettype none
module tb_timestamp_to_calendar_date;
    import tcd_pkg::*;

    localparam int          N_RANDOM     = 1880;
    localparam int          CYCLE_LIMIT  = 6000000;
    localparam int          DRAIN_CYCLES = 400;
    localparam longint unsigned TICKS_SEC = 64'd10000000;
    localparam longint unsigned LAST_SEC  = 64'd253402300799;

    typedef struct {
        logic  command;
        logic [63:0] timestamp;
        bit    fixed;
        t_res  res;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic push = 1'b0;
    logic pop = 1'b0;
    t_req i_req = '0;
    logic full;
    logic empty;
    t_res o_res;

    t_res pending_dates[$];
    int   n_errors = 0;
    int   n_checked = 0;
    int   n_before = 0;
    int   n_beyond = 0;
    int   cycles = 0;
    bit   sender_steady = 1'b0;
    bit   reader_steady = 1'b0;

    timestamp_to_calendar_date dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .push   (push),
        .full   (full),
        .i_req  (i_req),
        .empty  (empty),
        .pop    (pop),
        .o_res  (o_res)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycles);
            $display("Verification failed");
            $finish;
        end
    end

    function automatic bit is_leap_year(int unsigned y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic t_res calendar_of(t_req req);
        t_res r;
        longint unsigned secs;
        longint unsigned days;
        longint unsigned sod;
        longint unsigned whole;
        int unsigned y;
        int unsigned mo;
        int unsigned dm;
        int unsigned mlen[12];
        r = '0;
        mlen = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
        secs = req.timestamp;
        if (req.command) begin
            whole = secs / TICKS_SEC;
            if (whole < EPOCH_GAP_SECS) begin
                r.status = ST_BEFORE;
                return r;
            end
            secs = whole - EPOCH_GAP_SECS;
        end
        days = secs / 86400;
        sod = secs % 86400;
        y = FIRST_YEAR;
        forever begin
            if (y > MAX_YEAR) begin
                r.status = ST_BEYOND;
                return r;
            end
            if (days < (is_leap_year(y) ? 366 : 365)) break;
            days -= is_leap_year(y) ? 366 : 365;
            y++;
        end
        mo = 1;
        while (mo < 12) begin
            dm = (mo == 2 && is_leap_year(y)) ? 29 : mlen[mo-1];
            if (days < dm) break;
            days -= dm;
            mo++;
        end
        r.status = ST_OK;
        r.year   = 14'(y);
        r.month  = 4'(mo);
        r.day    = 5'(days + 1);
        r.hour   = 5'(sod / 3600);
        r.minute = 6'((sod % 3600) / 60);
        r.second = 6'(sod % 60);
        return r;
    endfunction

    function automatic int gap_len(bit steady);
        int r;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 20);
        return $urandom_range(30, 250);
    endfunction

    task automatic report(string field, t_res got, t_res want);
        n_errors++;
        $display("Mismatch in %s: got %p, expected %p", field, got, want);
    endtask

    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n && pop && !empty) begin
            if (pending_dates.size() == 0) begin
                report("unexpected result", o_res, '0);
            end else begin
                want = pending_dates.pop_front();
                n_checked++;
                if (o_res.status != want.status) report("status", o_res, want);
                if (o_res.year != want.year) report("year", o_res, want);
                if (o_res.month != want.month) report("month", o_res, want);
                if (o_res.day != want.day) report("day", o_res, want);
                if (o_res.hour != want.hour) report("hour", o_res, want);
                if (o_res.minute != want.minute) report("minute", o_res, want);
                if (o_res.second != want.second) report("second", o_res, want);
            end
        end
        if (cycles % 500 == 0) reader_steady <= ($urandom_range(0, 3) == 0);
        pop <= i_rst_n && (gap_len(reader_steady) == 0);
    end

    task automatic send(logic command, logic [63:0] ts, bit fixed, t_res res);
        t_req req;
        t_res want;
        int gap;
        req.command = command;
        req.timestamp = ts;
        gap = gap_len(sender_steady);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push <= 1'b1;
        i_req <= req;
        do @(posedge i_clk); while (full);
        want = fixed ? res : calendar_of(req);
        if (want.status == ST_BEFORE) n_before++;
        if (want.status == ST_BEYOND) n_beyond++;
        pending_dates.push_back(want);
    endtask

    function automatic logic [63:0] random_timestamp();
        int r;
        logic [63:0] secs;
        r = $urandom_range(0, 999);
        if (r < 580) return 64'($urandom);
        if (r < 800) begin
            secs = 64'($urandom);
            return (secs + EPOCH_GAP_SECS) * TICKS_SEC + $urandom_range(0, 9999999);
        end
        if (r < 850) return {$urandom, $urandom} % (EPOCH_GAP_SECS * TICKS_SEC);
        if (r < 960) return 64'($urandom_range(0, 86400 * 4)) + 64'd946684800 *
                            $urandom_range(0, 4);
        if (r < 990) return {$urandom, $urandom} % (LAST_SEC + 64'd86400);
        return {$urandom, $urandom};
    endfunction

    initial begin
        t_row rows[$];
        t_res ok_first;
        t_res ok_last;
        t_res bad_before;
        t_res bad_beyond;
        logic [63:0] ts;
        ok_first = '{status: ST_OK, year: 14'd1970, month: 4'd1, day: 5'd1, default: '0};
        ok_last = '{status: ST_OK, year: 14'd9999, month: 4'd12, day: 5'd31,
                    hour: 5'd23, minute: 6'd59, second: 6'd59};
        bad_before = '{status: ST_BEFORE, default: '0};
        bad_beyond = '{status: ST_BEYOND, default: '0};
        rows = '{
            '{1'b0, 64'd0, 1'b1, ok_first},
            '{1'b0, LAST_SEC, 1'b1, ok_last},
            '{1'b0, LAST_SEC + 1, 1'b1, bad_beyond},
            '{1'b0, '1, 1'b1, bad_beyond},
            '{1'b1, 64'd0, 1'b1, bad_before},
            '{1'b1, EPOCH_GAP_SECS * TICKS_SEC - 1, 1'b1, bad_before},
            '{1'b1, EPOCH_GAP_SECS * TICKS_SEC, 1'b1, ok_first},
            '{1'b1, EPOCH_GAP_SECS * TICKS_SEC + TICKS_SEC - 1, 1'b1, ok_first},
            '{1'b1, (EPOCH_GAP_SECS + LAST_SEC) * TICKS_SEC + TICKS_SEC - 1, 1'b1, ok_last},
            '{1'b1, (EPOCH_GAP_SECS + LAST_SEC + 1) * TICKS_SEC, 1'b1, bad_beyond},
            '{1'b1, '1, 1'b1, bad_beyond},
            '{1'b0, 64'd86399, 1'b0, '0},
            '{1'b0, 64'd68169599, 1'b0, '0},
            '{1'b0, 64'd68169600, 1'b0, '0},
            '{1'b0, 64'd951782400, 1'b0, '0},
            '{1'b0, 64'd951868800, 1'b0, '0},
            '{1'b0, 64'd4107456000, 1'b0, '0},
            '{1'b0, 64'd4107542400, 1'b0, '0},
            '{1'b0, 64'd978307199, 1'b0, '0},
            '{1'b1, 64'h5555_5555_5555_5555, 1'b0, '0},
            '{1'b1, 64'h0AAA_AAAA_AAAA_AAAA, 1'b0, '0},
            '{1'b0, 64'hAAAA_AAAA, 1'b0, '0}
        };
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (rows[k]) send(rows[k].command, rows[k].timestamp, rows[k].fixed, rows[k].res);
        for (int k = 0; k < N_RANDOM; k++) begin
            if (k % 100 == 0) sender_steady = ($urandom_range(0, 3) == 0);
            ts = random_timestamp();
            send(1'(ts[63] ^ ts[0] ? $urandom_range(0, 1) : (ts > 64'hFFFF_FFFF_FFFF)), ts,
                 1'b0, '0);
        end
        push <= 1'b0;
        while (pending_dates.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Checked %0d conversions from %0d requests, %0d before 1970, %0d beyond limit.",
                 n_checked, rows.size() + N_RANDOM, n_before, n_beyond);
        $display("Mismatches: %0d", n_errors);
        if (n_errors == 0 && pending_dates.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
`default_nettype wire
